[src/etl_pkg.sv]
// shared types, widths and constants of the escape-time block
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package etl_pkg;

   localparam int FRAC_BITS = 27;
   localparam int ITER_BITS = 16;
   localparam int IN_W      = 30;
   localparam int NUM_CH    = 3;

   // z coordinates hold the q5 range, squares saturate at 32.0
   localparam int Z_W    = FRAC_BITS + 5;
   localparam int SQ_W   = FRAC_BITS + 7;
   localparam int SUM_W  = ((SQ_W > IN_W) ? SQ_W : IN_W) + 2;
   localparam int PROD_W = 2 * Z_W;
   localparam int MAG_W  = PROD_W - FRAC_BITS;

   localparam int REQ_W = ((2 * IN_W + 7) / 8) * 8;
   localparam int RSP_W = ((NUM_CH * (ITER_BITS + 1) + 7) / 8) * 8;

   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   typedef logic signed [IN_W-1:0]            cin_type;
   typedef logic signed [Z_W-1:0]             z_type;
   typedef logic signed [SQ_W-1:0]            sq_type;
   typedef logic signed [SUM_W-1:0]           sum_type;
   typedef logic [PROD_W-1:0]                 prod_type;
   typedef logic [MAG_W-1:0]                  mag_type;
   typedef logic [ITER_BITS-1:0]              iter_type;
   typedef logic [NUM_CH-1:0][ITER_BITS-1:0]  lim_vec_type;
   typedef logic [1:0]                        csr_idx_type;

   localparam csr_idx_type CSR_LIMIT_RED   = 2'd0;
   localparam csr_idx_type CSR_LIMIT_GREEN = 2'd1;
   localparam csr_idx_type CSR_LIMIT_BLUE  = 2'd2;

   localparam iter_type LIMIT_RESET_RED   = ITER_BITS'(200);
   localparam iter_type LIMIT_RESET_GREEN = ITER_BITS'(600);
   localparam iter_type LIMIT_RESET_BLUE  = ITER_BITS'(300);

   localparam int ESCAPE_RADIUS_SQ = 4;
   localparam sum_type ESCAPE_SQ   = SUM_W'(ESCAPE_RADIUS_SQ) << FRAC_BITS;
   localparam mag_type SAT_MAG     = MAG_W'(1) << (FRAC_BITS + 5);
   localparam sum_type Z_MAX       = (SUM_W'(1) << (Z_W - 1)) - SUM_W'(1);
   localparam sum_type Z_MIN       = -(SUM_W'(1) << (Z_W - 1));

   typedef struct packed {
      logic start;
      logic upd;
      logic mul;
      logic nrm;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic all_ended;
   } dp_status_type;

endpackage

`default_nettype wire

[src/etl_datapath.sv]
// orbit datapath: z registers, three multipliers, normalize, escape and limit checks
// depends on etl_pkg; driven by etl_ctrl through dp_cmd_type
`timescale 1ns / 1ps
`default_nettype none

module etl_datapath (
   input  wire                   clock,
   input  wire                   reset,
   input  etl_pkg::dp_cmd_type   cmd,
   output etl_pkg::dp_status_type status,
   input  etl_pkg::cin_type      c_real,
   input  etl_pkg::cin_type      c_imag,
   input  etl_pkg::lim_vec_type  limit,
   output logic [etl_pkg::NUM_CH-1:0] escaped,
   output etl_pkg::lim_vec_type  steps
);
   import etl_pkg::*;

   cin_type cr_ff, ci_ff;
   z_type   x_ff, y_ff;
   prod_type pxx_ff, pyy_ff, pxy_ff;
   logic    nxy_ff;
   sq_type  xx_ff, yy_ff, xy_ff;
   iter_type n_ff;
   logic    first_ff;

   logic [NUM_CH-1:0] live_ff, live_in;
   logic [NUM_CH-1:0] esc_ff, esc_in;
   lim_vec_type       steps_ff, steps_in;
   logic [NUM_CH-1:0] esc_out_ff;
   lim_vec_type       steps_out_ff;

   sum_type x_sum, y_sum;
   logic    esc_hit;
   logic [Z_W-1:0] ax, ay;

   function automatic z_type clamp_z(input sum_type v);
      z_type r;
      if (v > Z_MAX) begin
         r = Z_W'(Z_MAX);
      end else if (v < Z_MIN) begin
         r = Z_W'(Z_MIN);
      end else begin
         r = Z_W'(v);
      end
      return r;
   endfunction

   function automatic logic [Z_W-1:0] abs_z(input z_type v);
      logic [Z_W-1:0] r;
      r = v[Z_W-1] ? (~v + 1'b1) : v;
      return r;
   endfunction

   // floor of the scaled product, magnitude saturated at 32.0
   function automatic sq_type norm(input prod_type p, input logic neg);
      mag_type mag;
      logic    rem_nz;
      sq_type  m_s;
      sq_type  r;
      mag    = p[PROD_W-1:FRAC_BITS];
      rem_nz = |p[FRAC_BITS-1:0];
      if (mag > SAT_MAG) begin
         mag    = SAT_MAG;
         rem_nz = 1'b0;
      end
      m_s = sq_type'(SQ_W'(mag));
      r   = neg ? (-m_s - SQ_W'(rem_nz)) : m_s;
      return r;
   endfunction

   assign x_sum = SUM_W'(xx_ff) - SUM_W'(yy_ff) + SUM_W'(cr_ff);
   assign y_sum = (SUM_W'(xy_ff) <<< 1) + SUM_W'(ci_ff);
   assign esc_hit = (SUM_W'(xx_ff) + SUM_W'(yy_ff)) > ESCAPE_SQ;
   assign ax = abs_z(x_ff);
   assign ay = abs_z(y_ff);

   // limit check right after the count step, escape check one step later
   always_comb begin
      live_in  = live_ff;
      esc_in   = esc_ff;
      steps_in = steps_ff;
      if (cmd.start) begin
         live_in = '1;
      end else if (cmd.upd && !first_ff) begin
         for (int k = 0; k < NUM_CH; k++) begin
            if (live_ff[k] && esc_hit) begin
               live_in[k]  = 1'b0;
               esc_in[k]   = 1'b1;
               steps_in[k] = n_ff;
            end
         end
      end else if (cmd.mul) begin
         for (int k = 0; k < NUM_CH; k++) begin
            if (live_ff[k] && (n_ff == limit[k])) begin
               live_in[k]  = 1'b0;
               esc_in[k]   = 1'b0;
               steps_in[k] = n_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff  <= '0;
         first_ff <= 1'b0;
      end else begin
         live_ff <= live_in;
         if (cmd.start) begin
            first_ff <= 1'b1;
         end else if (cmd.upd) begin
            first_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      esc_ff   <= esc_in;
      steps_ff <= steps_in;
      if (cmd.start) begin
         cr_ff <= c_real;
         ci_ff <= c_imag;
         xx_ff <= '0;
         yy_ff <= '0;
         xy_ff <= '0;
         n_ff  <= '0;
      end
      if (cmd.upd) begin
         x_ff <= clamp_z(x_sum);
         y_ff <= clamp_z(y_sum);
         n_ff <= n_ff + 1'b1;
      end
      if (cmd.mul) begin
         pxx_ff <= ax * ax;
         pyy_ff <= ay * ay;
         pxy_ff <= ax * ay;
         nxy_ff <= x_ff[Z_W-1] ^ y_ff[Z_W-1];
      end
      if (cmd.nrm) begin
         xx_ff <= norm(pxx_ff, 1'b0);
         yy_ff <= norm(pyy_ff, 1'b0);
         xy_ff <= norm(pxy_ff, nxy_ff);
      end
      if (cmd.load_out) begin
         esc_out_ff   <= esc_ff;
         steps_out_ff <= steps_ff;
      end
   end

   assign status.all_ended = (live_ff == '0);
   assign escaped = esc_out_ff;
   assign steps   = steps_out_ff;

endmodule

`default_nettype wire

[src/etl_ctrl.sv]
// sequencer: input and result handshakes, one orbit step per update/multiply/normalize round
// depends on etl_pkg; drives etl_datapath through dp_cmd_type
`timescale 1ns / 1ps
`default_nettype none

module etl_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output etl_pkg::dp_cmd_type    cmd,
   input  etl_pkg::dp_status_type status
);
   import etl_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_UPD  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_NRM  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ST_UPD;
            end
         end
         ST_UPD: begin
            if (status.all_ended) begin
               state_in = ST_FIN;
            end else begin
               cmd.upd  = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (status.all_ended) begin
               state_in = ST_FIN;
            end else begin
               cmd.mul  = 1'b1;
               state_in = ST_NRM;
            end
         end
         ST_NRM: begin
            if (status.all_ended) begin
               state_in = ST_FIN;
            end else begin
               cmd.nrm  = 1'b1;
               state_in = ST_UPD;
            end
         end
         ST_FIN: begin
            // wait for the result register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

[src/escape_time_three_limits.sv]
// Escape-time test of z <- z*z + c for one point c against three iteration limits
// (red, green, blue), all channels on one shared orbit in signed Q5.27. One point is
// worked at a time; each orbit step runs update, 32x32 multiply, then normalize.
// A limit of zero acts as one. The result register lets the next point start while
// the previous result waits. The user must write limits only while no point is in
// flight; the block itself does not enforce this.
// depends on etl_pkg, etl_ctrl and etl_datapath
`timescale 1ns / 1ps
`default_nettype none

module escape_time_three_limits (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   input  wire [etl_pkg::REQ_W-1:0]       req_tdata,   // c_real, c_imag, zero pad
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   // escaped_red, steps_red, escaped_green, steps_green, escaped_blue, steps_blue, pad
   output logic [etl_pkg::RSP_W-1:0]      rsp_tdata,
   input  wire                            csr_we,
   input  etl_pkg::csr_idx_type           csr_index,
   input  etl_pkg::iter_type              csr_wdata
);
   import etl_pkg::*;

   iter_type    limit_red_ff, limit_green_ff, limit_blue_ff;
   lim_vec_type lim_eff;
   dp_cmd_type  dp_cmd;
   dp_status_type dp_status;
   logic [NUM_CH-1:0] out_esc;
   lim_vec_type out_steps;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_red_ff   <= LIMIT_RESET_RED;
         limit_green_ff <= LIMIT_RESET_GREEN;
         limit_blue_ff  <= LIMIT_RESET_BLUE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LIMIT_RED:   limit_red_ff   <= csr_wdata;
            CSR_LIMIT_GREEN: limit_green_ff <= csr_wdata;
            CSR_LIMIT_BLUE:  limit_blue_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // zero limit behaves as one
   assign lim_eff[CH_RED]   = (limit_red_ff == '0)   ? ITER_BITS'(1) : limit_red_ff;
   assign lim_eff[CH_GREEN] = (limit_green_ff == '0) ? ITER_BITS'(1) : limit_green_ff;
   assign lim_eff[CH_BLUE]  = (limit_blue_ff == '0)  ? ITER_BITS'(1) : limit_blue_ff;

   etl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (dp_cmd),
      .status     (dp_status)
   );

   etl_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (dp_cmd),
      .status  (dp_status),
      .c_real  (req_tdata[IN_W-1:0]),
      .c_imag  (req_tdata[2*IN_W-1:IN_W]),
      .limit   (lim_eff),
      .escaped (out_esc),
      .steps   (out_steps)
   );

   assign rsp_tdata = RSP_W'({out_steps[CH_BLUE], out_esc[CH_BLUE],
                              out_steps[CH_GREEN], out_esc[CH_GREEN],
                              out_steps[CH_RED], out_esc[CH_RED]});

   a_one_point_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while a point is in flight");

   a_red_limit_steps: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load_out |=> (out_esc[CH_RED] || (out_steps[CH_RED] == lim_eff[CH_RED])))
      else $error("red channel ended without escape before its limit");

   a_green_escape_early: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load_out |=> (!out_esc[CH_GREEN] || (out_steps[CH_GREEN] < lim_eff[CH_GREEN])))
      else $error("green channel escaped at or past its limit");

   a_blue_steps_nonzero: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load_out |=> (out_steps[CH_BLUE] != '0))
      else $error("blue step count is zero");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// self-checking bench for escape_time_three_limits: escape flag and step count per color
// channel, predicted per point and checked against the result beats; depends on etl_pkg
`timescale 1ns / 1ps

module tb_top;
   import etl_pkg::*;

   localparam int     ONE         = 1 << FRAC_BITS;
   localparam int     IN_MAX      = (1 << (IN_W - 1)) - 1;
   localparam int     IN_MIN      = -(1 << (IN_W - 1));
   localparam longint Q5_TOP      = longint'(1) << (FRAC_BITS + 4);
   localparam longint SQ_SAT      = longint'(1) << (FRAC_BITS + 5);
   localparam longint FRAC_MASK   = (longint'(1) << FRAC_BITS) - 1;
   localparam longint ESCAPE_FOUR = longint'(ESCAPE_RADIUS_SQ) << FRAC_BITS;
   // a non-escaping point at limit 65535 runs its full orbit without a beat
   localparam int     STALL_LIMIT = 800_000;
   localparam int     RANDOM_PHASES = 8;
   localparam int     POINTS_PER_PHASE = 125;

   typedef struct packed {
      logic [REQ_W-2*IN_W-1:0] pad;
      cin_type                 c_imag;
      cin_type                 c_real;
   } req_beat_type;

   typedef struct packed {
      iter_type steps;
      logic     escaped;
   } chan_result_type;

   typedef struct packed {
      logic [RSP_W-NUM_CH*(ITER_BITS+1)-1:0] pad;
      chan_result_type [NUM_CH-1:0]          ch;
   } rsp_beat_type;

   typedef struct {
      req_beat_type point;
      rsp_beat_type result;
   } escape_record_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   wire               req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;   // c_real, c_imag, zero pad
   wire               rsp_tvalid;
   logic              rsp_tready = 1'b0;
   // escaped_red, steps_red, escaped_green, steps_green, escaped_blue, steps_blue, pad
   wire [RSP_W-1:0]   rsp_tdata;
   logic              csr_we = 1'b0;
   csr_idx_type       csr_index = CSR_LIMIT_RED;
   iter_type          csr_wdata = '0;

   escape_time_three_limits dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   req_beat_type      pending_points [$];
   escape_record_type escape_outcomes [$];
   iter_type       lim_model [NUM_CH] = '{LIMIT_RESET_RED, LIMIT_RESET_GREEN, LIMIT_RESET_BLUE};
   string          ch_name [NUM_CH] = '{"red", "green", "blue"};

   bit             idle_en = 1'b0;
   bit             point_taken = 1'b0;
   int             send_gap = 0;
   int             hold_cycles = 0;
   int             points_queued = 0;
   int             results_out = 0;
   int             escaped_seen = 0;
   int             settings_used = 1;
   int             fail_count = 0;
   int             stall_cycles = 0;
   rsp_beat_type      got;
   escape_record_type want;

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------- predictor ----------------

   // floor(p*q / 2^FRAC_BITS) with the magnitude held at 32.0
   function automatic longint fixed_mul(input longint p, input longint q);
      longint a, b, prod, mag;
      bit     rem_nz;
      a = (p < 0) ? -p : p;
      b = (q < 0) ? -q : q;
      prod = a * b;
      mag = prod >>> FRAC_BITS;
      rem_nz = (prod & FRAC_MASK) != 0;
      if (mag > SQ_SAT) begin
         mag = SQ_SAT;
         rem_nz = 1'b0;
      end
      if ((p < 0) != (q < 0))
         return rem_nz ? -mag - 1 : -mag;
      return mag;
   endfunction

   function automatic longint clamp_q5(input longint v);
      if (v >= Q5_TOP)
         return Q5_TOP - 1;
      if (v < -Q5_TOP)
         return -Q5_TOP;
      return v;
   endfunction

   function automatic void run_orbit(input cin_type cr, input cin_type ci, input iter_type lim_reg,
                                     output logic esc, output iter_type steps);
      longint      x, y, xx, yy, xy, re, im;
      int unsigned lim, n;
      bit          done;
      re = longint'(cr);
      im = longint'(ci);
      lim = (lim_reg == '0) ? 32'd1 : 32'(lim_reg);
      xx = 0;
      yy = 0;
      xy = 0;
      n = 0;
      done = 1'b0;
      esc = 1'b0;
      while (!done) begin
         x = clamp_q5(xx - yy + re);
         y = clamp_q5(2 * xy + im);
         n++;
         // the limit check wins over the escape test
         if (n == lim) begin
            done = 1'b1;
         end else begin
            xx = fixed_mul(x, x);
            yy = fixed_mul(y, y);
            xy = fixed_mul(x, y);
            if (xx + yy > ESCAPE_FOUR) begin
               esc = 1'b1;
               done = 1'b1;
            end
         end
      end
      steps = iter_type'(n);
   endfunction

   function automatic rsp_beat_type predict_point(input req_beat_type pt);
      rsp_beat_type r;
      logic      esc;
      iter_type  steps;
      r = '0;
      for (int k = 0; k < NUM_CH; k++) begin
         run_orbit(pt.c_real, pt.c_imag, lim_model[k], esc, steps);
         r.ch[k].escaped = esc;
         r.ch[k].steps = steps;
      end
      return r;
   endfunction

   // ---------------- driver and sink ----------------

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (!req_tvalid || point_taken) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_points.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(0, 9);
               req_tvalid <= 1'b0;
            end else begin
               req_tdata  <= pending_points.pop_front();
               req_tvalid <= 1'b1;
            end
         end
      end
      point_taken = 1'b0;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
         hold_cycles = $urandom_range(0, 9);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------- monitor, checker, watchdog ----------------

   task automatic log_failure(input string msg);
      if (fail_count < 10)
         $display("mismatch: %s", msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            want.point = req_beat_type'(req_tdata);
            want.result = predict_point(want.point);
            escape_outcomes.insert(escape_outcomes.size(), want);
            point_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_out++;
            got = rsp_beat_type'(rsp_tdata);
            if (escape_outcomes.size() == 0) begin
               log_failure($sformatf("result beat %h with no point outstanding", rsp_tdata));
            end else begin
               want = escape_outcomes.pop_front();
               for (int k = 0; k < NUM_CH; k++) begin
                  if (got.ch[k].escaped !== want.result.ch[k].escaped)
                     log_failure($sformatf("c=(%0d,%0d) escaped_%s expected %0b got %0b",
                        want.point.c_real, want.point.c_imag, ch_name[k],
                        want.result.ch[k].escaped, got.ch[k].escaped));
                  if (got.ch[k].steps !== want.result.ch[k].steps)
                     log_failure($sformatf("c=(%0d,%0d) steps_%s expected %0d got %0d",
                        want.point.c_real, want.point.c_imag, ch_name[k],
                        want.result.ch[k].steps, got.ch[k].steps));
                  if (want.result.ch[k].escaped)
                     escaped_seen++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (!req_tvalid && escape_outcomes.size() == 0)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("no beat for %0d cycles", STALL_LIMIT);
               $display("CHECK FAILED");
               $finish;
            end
         end
      end
   end

   // ---------------- stimulus ----------------

   function automatic req_beat_type make_point(input int re, input int im);
      req_beat_type b;
      b = '0;
      b.c_real = cin_type'(re);
      b.c_imag = cin_type'(im);
      return b;
   endfunction

   // called on a rising edge so the driver picks items up on the next falling edge
   task automatic queue_point(input req_beat_type b);
      pending_points.insert(pending_points.size(), b);
      points_queued++;
   endtask

   // real part at 0.5 or more keeps the orbit well clear of the set
   function automatic req_beat_type fast_escape_point();
      return make_point(int'($urandom_range(ONE / 2, 2 * ONE)),
                        int'($urandom_range(0, 4 * ONE)) - 2 * ONE);
   endfunction

   function automatic req_beat_type random_point();
      int special [10] = '{0, ONE, -ONE, 2 * ONE, -2 * ONE, ONE / 4, IN_MAX, IN_MIN, 1, -1};
      case ($urandom_range(0, 9))
         0, 1, 2, 3:
            return make_point(int'($urandom_range(0, 4 * ONE)) - 2 * ONE,
                              int'($urandom_range(0, 4 * ONE)) - 2 * ONE);
         4, 5, 6:
            // window around the set: real -2.0..0.5, imag -1.25..1.25
            return make_point(int'($urandom_range(0, 5 * (ONE / 2))) - 2 * ONE,
                              int'($urandom_range(0, 5 * (ONE / 2))) - 5 * (ONE / 4));
         7:
            return make_point(int'($urandom()), int'($urandom()));
         default:
            return make_point(special[$urandom_range(0, 9)], special[$urandom_range(0, 9)]);
      endcase
   endfunction

   function automatic iter_type pick_limit();
      case ($urandom_range(0, 9))
         0:       return iter_type'(0);
         1:       return iter_type'(1);
         2:       return iter_type'(2);
         3, 4, 5: return iter_type'($urandom_range(3, 24));
         6, 7, 8: return iter_type'($urandom_range(25, 80));
         default: return iter_type'($urandom_range(81, 200));
      endcase
   endfunction

   task automatic wait_results_done();
      while (results_out < points_queued)
         @(negedge clock);
   endtask

   // limits change only once every point has come back
   task automatic set_limits(input iter_type red, input iter_type green, input iter_type blue);
      iter_type    vals [NUM_CH];
      csr_idx_type idx [NUM_CH];
      vals = '{red, green, blue};
      idx = '{CSR_LIMIT_RED, CSR_LIMIT_GREEN, CSR_LIMIT_BLUE};
      wait_results_done();
      repeat (8) @(negedge clock);
      for (int k = 0; k < NUM_CH; k++) begin
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= vals[k];
         lim_model[idx[k]] = vals[k];
      end
      @(negedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int drain;
      int top;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset limits: boundary, bounded and quickly escaping points
      @(posedge clock);
      idle_en = 1'b1;
      queue_point(make_point(0, 0));
      queue_point(make_point(-2 * ONE, 0));            // |z|^2 sits at exactly 4.0
      queue_point(make_point(2 * ONE, 0));
      queue_point(make_point(2 * ONE, 2 * ONE));
      queue_point(make_point(-2 * ONE, -2 * ONE));
      queue_point(make_point(0, 2 * ONE));
      queue_point(make_point(0, -2 * ONE));
      queue_point(make_point(0, ONE));
      queue_point(make_point(-ONE, 0));
      queue_point(make_point(ONE / 4, 0));
      queue_point(make_point(ONE / 4 + (1 << 14), 0)); // slow escape past the cusp
      queue_point(make_point(-3 * (ONE / 4), 0));
      queue_point(make_point(IN_MAX, IN_MAX));         // outside -2.0..2.0
      queue_point(make_point(IN_MIN, IN_MIN));
      queue_point(make_point(IN_MAX, IN_MIN));
      queue_point(make_point(1, -1));
      queue_point(make_point(-1, 1));

      // zero limit, limit one and the widest limit
      set_limits(iter_type'(0), iter_type'(1), iter_type'(16'hFFFF));
      @(posedge clock);
      queue_point(make_point(0, 0));
      queue_point(make_point(2 * ONE, 0));
      queue_point(make_point(2 * ONE, 2 * ONE));
      repeat (3) queue_point(fast_escape_point());

      set_limits(iter_type'(16'hFFFF), iter_type'(16'hFFFE), iter_type'(1));
      @(posedge clock);
      queue_point(make_point(IN_MIN, IN_MIN));
      queue_point(make_point(IN_MAX, 0));
      repeat (3) queue_point(fast_escape_point());

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         set_limits(pick_limit(), pick_limit(), pick_limit());
         @(posedge clock);
         // the last phase runs with no idling on either side
         idle_en = (ph < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
         repeat (POINTS_PER_PHASE) queue_point(random_point());
      end

      wait_results_done();
      top = 1;
      for (int k = 0; k < NUM_CH; k++)
         if (int'(lim_model[k]) > top)
            top = int'(lim_model[k]);
      drain = 3 * top + 20;
      repeat (drain) @(negedge clock);
      if (escape_outcomes.size() != 0)
         log_failure($sformatf("%0d points never answered", escape_outcomes.size()));

      $display("%0d points checked over %0d limit settings, %0d channel escapes among them",
               results_out, settings_used, escaped_seen);
      $display("%0d failures", fail_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
